>>> hdl/srr_pkg.sv
// Shared types and constants for the three-sensor ultrasonic ranger.
// No dependencies; used by every module in hdl/.
package srr_pkg;

   // Phase of the scan sequencer, one-hot
   typedef enum logic [3:0] {
      PH_TRIG  = 4'b0001,
      PH_WAIT  = 4'b0010,
      PH_HIGH  = 4'b0100,
      PH_PAUSE = 4'b1000
   } phase_type;

   // Sensor selector codes
   localparam logic [1:0] SENSOR_LEFT  = 2'd0;
   localparam logic [1:0] SENSOR_FRONT = 2'd1;
   localparam logic [1:0] SENSOR_RIGHT = 2'd2;

   // Register indexes on the csr port
   localparam logic [1:0] CSR_NEAR_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_ECHO_TIMEOUT   = 2'd1;
   localparam logic [1:0] CSR_TRIGGER_TICKS  = 2'd2;
   localparam logic [1:0] CSR_PAUSE_TICKS    = 2'd3;

   // Register reset values
   localparam logic [10:0] NEAR_THRESHOLD_RST = 11'd40;
   localparam logic [15:0] ECHO_TIMEOUT_RST   = 16'd60000;
   localparam logic [7:0]  TRIGGER_TICKS_RST  = 8'd10;
   localparam logic [23:0] PAUSE_TICKS_RST    = 24'd100000;

   // Distance conversion: last remainder (ticks per centimetre minus one) and the timeout report value
   localparam logic [5:0]  DIV_CM_LAST   = 6'd57;
   localparam logic [10:0] TIMEOUT_VALUE = 11'd999;
   // A zero echo timeout acts as the full 16-bit wrap
   localparam logic [16:0] TIMEOUT_WRAP  = 17'h10000;

   typedef struct packed {
      logic [10:0] near_threshold;
      logic [15:0] echo_timeout;
      logic [7:0]  trigger_ticks;
      logic [23:0] pause_ticks;
   } cfg_type;

   // Registered input item; echo[0] left, [1] front, [2] right
   typedef struct packed {
      logic       valid;
      logic [2:0] echo;
   } in_item_type;

   typedef struct packed {
      logic green;
      logic yellow;
      logic red;
      logic buzzer;
   } lamp_type;

   typedef struct packed {
      logic [2:0]  trig;
      lamp_type    lamps;
      logic        range_done;
      logic [1:0]  range_sensor;
      logic [10:0] range_value;
      logic        range_timeout;
   } result_type;

endpackage

>>> hdl/srr_in_reg.sv
// Input register stage of the ranger: holds one sampled echo item.
// Depends on srr_pkg.
module srr_in_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [2:0]          in_echo,
   input  logic                take,     // core consumes the held item
   output srr_pkg::in_item_type item
);

   logic       valid_ff, valid_in;
   logic [2:0] echo_ff;

   // stage frees when empty or when the held item moves on
   assign in_ready = !valid_ff || take;
   assign valid_in = in_valid || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         echo_ff <= in_echo;
      end
   end

   assign item.valid = valid_ff;
   assign item.echo  = echo_ff;

endmodule

>>> hdl/srr_core.sv
// Scan sequencer, echo timing, distance and lamp logic with the result register.
// Depends on srr_pkg.
module srr_core #(
   parameter int COUNT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  srr_pkg::cfg_type      cfg,
   input  srr_pkg::in_item_type  item,
   output logic                  take,
   output logic                  out_valid,
   input  logic                  out_ready,
   output srr_pkg::result_type   result
);

   srr_pkg::phase_type phase_ff, phase_in;
   logic [1:0]            sel_ff, sel_in;
   logic [23:0]           ticks_ff, ticks_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [5:0]            rem_ff, rem_in;      // echo count mod 58
   logic [10:0]           quot_ff, quot_in;    // echo count / 58, low 11 bits
   logic [10:0]           dist_left_ff, dist_left_in;
   logic [10:0]           dist_front_ff, dist_front_in;
   srr_pkg::lamp_type     lamps_ff, lamps_in;
   logic                  out_valid_ff;
   srr_pkg::result_type   result_ff, result_in;

   logic        step;
   logic        echo;
   logic [24:0] ticks_inc;
   logic [16:0] lim;
   logic [7:0]  trig_len;
   logic        done, tmo;
   logic [10:0] value;
   logic [2:0]  trig;

   assign take = !out_valid_ff || out_ready;
   assign step = item.valid && take;

   assign ticks_inc = {1'b0, ticks_ff} + 25'd1;
   assign lim       = (cfg.echo_timeout == 16'd0) ? srr_pkg::TIMEOUT_WRAP
                                                  : {1'b0, cfg.echo_timeout};
   assign trig_len  = (cfg.trigger_ticks == 8'd0) ? 8'd1 : cfg.trigger_ticks;

   // echo of the sensor being measured
   always_comb begin
      case (sel_ff)
         srr_pkg::SENSOR_LEFT:  echo = item.echo[0];
         srr_pkg::SENSOR_FRONT: echo = item.echo[1];
         default:               echo = item.echo[2];
      endcase
   end

   // one tick of the sequencer
   always_comb begin
      phase_in      = phase_ff;
      sel_in        = sel_ff;
      ticks_in      = ticks_ff;
      count_in      = count_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      dist_left_in  = dist_left_ff;
      dist_front_in = dist_front_ff;
      lamps_in      = lamps_ff;
      done          = 1'b0;
      tmo           = 1'b0;
      value         = quot_ff;
      trig          = 3'b000;

      case (phase_ff)
         srr_pkg::PH_TRIG: begin
            case (sel_ff)
               srr_pkg::SENSOR_LEFT:  trig = 3'b001;
               srr_pkg::SENSOR_FRONT: trig = 3'b010;
               default:               trig = 3'b100;
            endcase
            ticks_in = ticks_inc[23:0];
            if (ticks_inc >= {17'd0, trig_len}) begin
               phase_in = srr_pkg::PH_WAIT;
               ticks_in = 24'd0;
            end
         end
         srr_pkg::PH_WAIT: begin
            if (echo) begin
               phase_in = srr_pkg::PH_HIGH;
               ticks_in = 24'd0;
               count_in = '0;
               rem_in   = 6'd0;
               quot_in  = 11'd0;
            end else begin
               ticks_in = ticks_inc[23:0];
               if (ticks_inc >= {8'd0, lim}) begin
                  done = 1'b1;
                  tmo  = 1'b1;
               end
            end
         end
         srr_pkg::PH_HIGH: begin
            if (echo) begin
               count_in = count_ff + 1'b1;
               // quotient tracks the count, restarting when the count wraps
               if (&count_ff) begin
                  rem_in  = 6'd0;
                  quot_in = 11'd0;
               end else if (rem_ff == srr_pkg::DIV_CM_LAST) begin
                  rem_in  = 6'd0;
                  quot_in = quot_ff + 11'd1;
               end else begin
                  rem_in  = rem_ff + 6'd1;
               end
               ticks_in = ticks_inc[23:0];
               if (ticks_inc >= {8'd0, lim}) begin
                  done = 1'b1;
                  tmo  = 1'b1;
               end
            end else begin
               done = 1'b1;
            end
         end
         default: begin
            ticks_in = ticks_inc[23:0];
            if (ticks_inc >= {1'b0, cfg.pause_ticks}) begin
               phase_in = srr_pkg::PH_TRIG;
               ticks_in = 24'd0;
               sel_in   = srr_pkg::SENSOR_LEFT;
            end
         end
      endcase

      // measurement finished: store, advance sensor, lamps after the right one
      if (done) begin
         if (tmo) begin
            value = srr_pkg::TIMEOUT_VALUE;
         end
         ticks_in = 24'd0;
         case (sel_ff)
            srr_pkg::SENSOR_LEFT: begin
               dist_left_in = value;
               sel_in       = srr_pkg::SENSOR_FRONT;
               phase_in     = srr_pkg::PH_TRIG;
            end
            srr_pkg::SENSOR_FRONT: begin
               dist_front_in = value;
               sel_in        = srr_pkg::SENSOR_RIGHT;
               phase_in      = srr_pkg::PH_TRIG;
            end
            default: begin
               lamps_in = '0;
               if (value < cfg.near_threshold) begin
                  lamps_in.red    = 1'b1;
                  lamps_in.buzzer = 1'b1;
               end else if (dist_front_ff < cfg.near_threshold) begin
                  lamps_in.yellow = 1'b1;
               end else if (dist_left_ff < cfg.near_threshold) begin
                  lamps_in.green = 1'b1;
               end
               if (cfg.pause_ticks == 24'd0) begin
                  sel_in   = srr_pkg::SENSOR_LEFT;
                  phase_in = srr_pkg::PH_TRIG;
               end else begin
                  phase_in = srr_pkg::PH_PAUSE;
               end
            end
         endcase
      end

      result_in.trig          = trig;
      result_in.lamps         = lamps_in;
      result_in.range_done    = done;
      result_in.range_sensor  = done ? sel_ff : 2'd0;
      result_in.range_value   = done ? value : 11'd0;
      result_in.range_timeout = done && tmo;
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= srr_pkg::PH_TRIG;
         sel_ff        <= srr_pkg::SENSOR_LEFT;
         ticks_ff      <= 24'd0;
         count_ff      <= '0;
         rem_ff        <= 6'd0;
         quot_ff       <= 11'd0;
         dist_left_ff  <= 11'd0;
         dist_front_ff <= 11'd0;
         lamps_ff      <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         sel_ff        <= sel_in;
         ticks_ff      <= ticks_in;
         count_ff      <= count_in;
         rem_ff        <= rem_in;
         quot_ff       <= quot_in;
         dist_left_ff  <= dist_left_in;
         dist_front_ff <= dist_front_in;
         lamps_ff      <= lamps_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (take) begin
         out_valid_ff <= item.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         result_ff <= result_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign result    = result_ff;

   // at most one trigger driven at a time
   a_trig_onehot: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> $onehot0(result_ff.trig))
      else $error("more than one trigger driven");

   // buzzer always follows the red lamp, and only one lamp is lit
   a_lamps: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (result_ff.lamps.buzzer == result_ff.lamps.red) &&
                       $onehot0({result_ff.lamps.green, result_ff.lamps.yellow,
                                 result_ff.lamps.red}))
      else $error("lamp pattern inconsistent");

   // range fields are quiet when no measurement finished
   a_range_quiet: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !result_ff.range_done) |->
         (result_ff.range_value == 11'd0) && (result_ff.range_sensor == 2'd0) &&
         !result_ff.range_timeout)
      else $error("range fields set without a finished measurement");

   // sensor selector never leaves the three sensors
   a_sel_range: assert property (@(posedge clock) disable iff (reset)
      sel_ff != 2'd3)
      else $error("sensor selector out of range");

   // a timeout always reports the timeout value
   a_tmo_value: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && result_ff.range_timeout) |->
         (result_ff.range_value == srr_pkg::TIMEOUT_VALUE))
      else $error("timeout without timeout value");

endmodule

>>> hdl/three_sensor_ultrasonic_ranger.sv
// Top level of the three-sensor ultrasonic ranger: csr registers, port packing.
// Depends on srr_pkg, srr_in_reg and srr_core.
//
//  channel  | direction | handshake            | payload
//  req_     | in        | req_tvalid/tready    | req_tdata: echo levels
//  rsp_     | out       | rsp_tvalid/tready    | rsp_tdata: triggers, lamps, range; rsp_tuser
//  csr_     | in        | csr_wr_en            | csr_index, csr_wdata
//
// One tick item in, one result item out; a new item is taken every cycle unless a stalled result holds it.
// Each item passes through the input register, then the sequencer step into the result register.
// Reset (synchronous) empties both registers and restarts at the left sensor trigger.
// A stalled rsp_tready holds the result; up to one more item waits in the input register.
module three_sensor_ultrasonic_ranger #(
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] echo_left, [1] echo_front, [2] echo_right
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] trig_left, [1] trig_front, [2] trig_right, [3] lamp_green, [4] lamp_yellow,
   // [5] lamp_red, [6] buzzer_on, [8:7] range_sensor, [19:9] range_value,
   // [20] range_timeout
   output logic [23:0] rsp_tdata,
   output logic        rsp_tuser,   // range_done
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   srr_pkg::cfg_type     cfg_ff;
   srr_pkg::in_item_type item;
   srr_pkg::result_type  result;
   logic                 take;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.near_threshold <= srr_pkg::NEAR_THRESHOLD_RST;
         cfg_ff.echo_timeout   <= srr_pkg::ECHO_TIMEOUT_RST;
         cfg_ff.trigger_ticks  <= srr_pkg::TRIGGER_TICKS_RST;
         cfg_ff.pause_ticks    <= srr_pkg::PAUSE_TICKS_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            srr_pkg::CSR_NEAR_THRESHOLD: cfg_ff.near_threshold <= csr_wdata[10:0];
            srr_pkg::CSR_ECHO_TIMEOUT:   cfg_ff.echo_timeout   <= csr_wdata[15:0];
            srr_pkg::CSR_TRIGGER_TICKS:  cfg_ff.trigger_ticks  <= csr_wdata[7:0];
            srr_pkg::CSR_PAUSE_TICKS:    cfg_ff.pause_ticks    <= csr_wdata;
            default: ;
         endcase
      end
   end

   srr_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_echo  (req_tdata[2:0]),
      .take     (take),
      .item     (item)
   );

   srr_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .item      (item),
      .take      (take),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .result    (result)
   );

   // pack the result item
   assign rsp_tdata = {3'b000,
                       result.range_timeout,
                       result.range_value,
                       result.range_sensor,
                       result.lamps.buzzer,
                       result.lamps.red,
                       result.lamps.yellow,
                       result.lamps.green,
                       result.trig};
   assign rsp_tuser = result.range_done;

endmodule

>>> bench/tb_three_sensor_ultrasonic_ranger.sv
// Self-checking testbench for three_sensor_ultrasonic_ranger: echo ticks in, results out.
// A cycle-level tracker predicts every result item; the echo patterns follow the predicted scan.
// Depends on srr_pkg and the RTL in hdl/; needs nothing else.
module tb_three_sensor_ultrasonic_ranger;
   timeunit 1ns;
   timeprecision 1ps;
   import srr_pkg::*;

   localparam int COUNT_BITS      = 16;
   localparam int DIV_CM          = DIV_CM_LAST + 1;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int REPORT_LIMIT    = 10;
   localparam int RANDOM_TICKS    = 200;
   localparam int RANDOM_READINGS = 8;
   localparam int SETTLE_CYCLES   = 4;

   // How the echo of the sensor being measured behaves during one measurement
   typedef enum {PLAN_NORMAL, PLAN_SILENT, PLAN_STUCK, PLAN_NOISY} echo_shape_type;
   typedef struct {
      echo_shape_type shape;
      int             rise;    // ticks in the wait phase before the echo rises
      int             width;   // counted high ticks before the echo falls
   } echo_plan_type;

   // Tracks the ranger tick by tick and holds the result items still to come
   class ranging_tracker;
      cfg_type                 cfg;
      phase_type               phase;
      logic [1:0]              sensor;
      logic [23:0]             phase_ticks;
      logic [COUNT_BITS-1:0]   echo_count;
      logic [10:0]             distance [3];
      lamp_type                lamps;
      result_type              tick_outputs [$];
      int unsigned             ticks_taken, readings_done, timeouts_seen;
      int unsigned             results_checked, errors;

      function new();
         cfg = '{near_threshold: NEAR_THRESHOLD_RST, echo_timeout: ECHO_TIMEOUT_RST,
                 trigger_ticks: TRIGGER_TICKS_RST, pause_ticks: PAUSE_TICKS_RST};
         phase = PH_TRIG;
         sensor = SENSOR_LEFT;
         phase_ticks = '0;
         echo_count = '0;
         foreach (distance[i]) distance[i] = '0;
         lamps = '0;
      endfunction

      function void write_register(logic [1:0] index, logic [23:0] value);
         case (index)
            CSR_NEAR_THRESHOLD: cfg.near_threshold = value[10:0];
            CSR_ECHO_TIMEOUT:   cfg.echo_timeout   = value[15:0];
            CSR_TRIGGER_TICKS:  cfg.trigger_ticks  = value[7:0];
            CSR_PAUSE_TICKS:    cfg.pause_ticks    = value[23:0];
            default: ;
         endcase
      endfunction

      // One tick of the scan sequencer
      function void take_tick(logic [2:0] echoes);
         logic [1:0]  sel;
         logic        echo, done, tmo;
         logic [10:0] value;
         int unsigned limit, trig_len;
         lamp_type    lit;
         result_type  r;
         sel = (sensor > SENSOR_RIGHT) ? SENSOR_RIGHT : sensor;
         echo = echoes[sel];
         limit = (cfg.echo_timeout == '0) ? TIMEOUT_WRAP : cfg.echo_timeout;
         trig_len = (cfg.trigger_ticks == '0) ? 1 : cfg.trigger_ticks;
         r = '0;
         done = 1'b0;
         tmo = 1'b0;
         value = '0;
         case (phase)
            PH_TRIG: begin
               r.trig[sel] = 1'b1;
               phase_ticks++;
               if (phase_ticks >= trig_len) begin
                  phase = PH_WAIT;
                  phase_ticks = '0;
               end
            end
            PH_WAIT: begin
               // the rising tick itself is not counted
               if (echo) begin
                  phase = PH_HIGH;
                  phase_ticks = '0;
                  echo_count = '0;
               end else begin
                  phase_ticks++;
                  if (phase_ticks >= limit) begin
                     done = 1'b1;
                     tmo = 1'b1;
                  end
               end
            end
            PH_HIGH: begin
               if (echo) begin
                  echo_count++;
                  phase_ticks++;
                  if (phase_ticks >= limit) begin
                     done = 1'b1;
                     tmo = 1'b1;
                  end
               end else begin
                  done = 1'b1;
                  value = 11'(echo_count / DIV_CM);
               end
            end
            default: begin
               phase_ticks++;
               if (phase_ticks >= cfg.pause_ticks) begin
                  phase = PH_TRIG;
                  phase_ticks = '0;
                  sensor = SENSOR_LEFT;
               end
            end
         endcase

         // measurement finished: store it, move on, lamps after the right sensor
         if (done) begin
            if (tmo) value = TIMEOUT_VALUE;
            distance[sel] = value;
            phase_ticks = '0;
            if (sel < SENSOR_RIGHT) begin
               sensor = sel + 1'b1;
               phase = PH_TRIG;
            end else begin
               lit = '0;
               if (distance[SENSOR_LEFT] < cfg.near_threshold) begin
                  lit = '0;
                  lit.green = 1'b1;
               end
               if (distance[SENSOR_FRONT] < cfg.near_threshold) begin
                  lit = '0;
                  lit.yellow = 1'b1;
               end
               if (distance[SENSOR_RIGHT] < cfg.near_threshold) begin
                  lit = '0;
                  lit.red = 1'b1;
                  lit.buzzer = 1'b1;
               end
               lamps = lit;
               if (cfg.pause_ticks == '0) begin
                  sensor = SENSOR_LEFT;
                  phase = PH_TRIG;
               end else begin
                  phase = PH_PAUSE;
               end
            end
            r.range_sensor = sel;
            r.range_value = value;
            r.range_timeout = tmo;
            readings_done++;
            if (tmo) timeouts_seen++;
         end
         r.lamps = lamps;
         r.range_done = done;
         ticks_taken++;
         tick_outputs.push_back(r);
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= REPORT_LIMIT) $display("result item %0d: %s", results_checked, msg);
      endfunction

      function void check_field(string name, int unsigned want, int unsigned got);
         if (want != got) flag($sformatf("%s expected %0d, got %0d", name, want, got));
      endfunction

      function void compare_output(logic [23:0] data, logic range_done);
         result_type want, got;
         got.trig          = data[2:0];
         got.lamps.green   = data[3];
         got.lamps.yellow  = data[4];
         got.lamps.red     = data[5];
         got.lamps.buzzer  = data[6];
         got.range_sensor  = data[8:7];
         got.range_value   = data[19:9];
         got.range_timeout = data[20];
         got.range_done    = range_done;
         if (tick_outputs.size() == 0) begin
            flag("result item with nothing pending");
            return;
         end
         want = tick_outputs.pop_front();
         check_field("trig", want.trig, got.trig);
         check_field("lamp_green", want.lamps.green, got.lamps.green);
         check_field("lamp_yellow", want.lamps.yellow, got.lamps.yellow);
         check_field("lamp_red", want.lamps.red, got.lamps.red);
         check_field("buzzer_on", want.lamps.buzzer, got.lamps.buzzer);
         check_field("range_done", want.range_done, got.range_done);
         check_field("range_sensor", want.range_sensor, got.range_sensor);
         check_field("range_value", want.range_value, got.range_value);
         check_field("range_timeout", want.range_timeout, got.range_timeout);
         results_checked++;
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [0] echo_left, [1] echo_front, [2] echo_right
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;    // trig [2:0], lamps [6:3], sensor [8:7], value [19:9], timeout [20]
   logic        rsp_tuser;    // range_done
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [23:0] csr_wdata;

   ranging_tracker tracker;
   echo_plan_type  plan;
   echo_plan_type  scripted_plans [$];
   logic           plan_live = 1'b0;
   int             burst_left = 0;
   int             idle_cycles = 0;
   int             pattern_left = 0;
   logic [15:0]    stall_pattern = '1;

   three_sensor_ultrasonic_ranger #(.COUNT_BITS(COUNT_BITS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // Handshake monitor: predict on accepted ticks, check accepted results, watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) tracker.take_tick(req_tdata[2:0]);
         if (rsp_tvalid && rsp_tready) tracker.compare_output(rsp_tdata, rsp_tuser);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("watchdog: no item moved for %0d cycles", idle_cycles);
               $display("tb_three_sensor_ultrasonic_ranger: FAIL");
               $finish;
            end
         end
      end
   end

   // Result side stalls on a rotating pattern; a new random pattern is drawn when the current one runs out
   always @(negedge clock) begin
      if (pattern_left == 0) begin
         pattern_left = $urandom_range(16, 96);
         case ($urandom_range(0, 3))
            0: stall_pattern = '1;
            1: stall_pattern = 16'($urandom) | 16'($urandom);
            2: stall_pattern = 16'($urandom);
            default: stall_pattern = 16'($urandom) & 16'($urandom);
         endcase
      end
      pattern_left--;
      rsp_tready <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
   end

   function void script(echo_shape_type shape, int rise, int width);
      echo_plan_type p;
      p.shape = shape;
      p.rise = rise;
      p.width = width;
      scripted_plans.push_back(p);
   endfunction

   // Echo levels for the next tick, shaped after the predicted scan position
   function automatic logic [2:0] next_echoes();
      logic [2:0] echoes;
      logic [1:0] sel;
      int         pick;
      bit         short_timeout;
      echoes = 3'($urandom_range(0, 7));
      sel = tracker.sensor;
      if (tracker.phase == PH_WAIT || tracker.phase == PH_HIGH) begin
         if (!plan_live) begin
            if (scripted_plans.size() != 0) begin
               plan = scripted_plans.pop_front();
            end else begin
               // long silent or stuck echoes only where the timeout is short
               pick = $urandom_range(0, 99);
               short_timeout = tracker.cfg.echo_timeout != '0 &&
                               tracker.cfg.echo_timeout <= 80;
               plan.shape = PLAN_NORMAL;
               if (short_timeout && pick < 10) plan.shape = PLAN_SILENT;
               else if (short_timeout && pick < 20) plan.shape = PLAN_STUCK;
               else if (pick < 30) plan.shape = PLAN_NOISY;
               plan.rise = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20)
                                                        : $urandom_range(0, 4);
               // some widths land right on the threshold boundary
               if (pick >= 80 && tracker.cfg.near_threshold != '0)
                  plan.width = DIV_CM * int'(tracker.cfg.near_threshold) -
                               int'($urandom_range(0, 1));
               else
                  plan.width = ($urandom_range(0, 3) == 0) ? $urandom_range(0, DIV_CM + 4)
                                                            : $urandom_range(0, 12);
            end
            plan_live = 1'b1;
         end
         case (plan.shape)
            PLAN_NORMAL: echoes[sel] = (tracker.phase == PH_WAIT) ?
                                       (tracker.phase_ticks >= plan.rise) :
                                       (tracker.echo_count < plan.width);
            PLAN_SILENT: echoes[sel] = 1'b0;
            PLAN_STUCK:  echoes[sel] = (tracker.phase == PH_HIGH) ||
                                       (tracker.phase_ticks >= plan.rise);
            default: ;
         endcase
      end else begin
         plan_live = 1'b0;
      end
      return echoes;
   endfunction

   // Send ticks in bursts until both the tick count and the reading count are reached
   task automatic run_ticks(int min_ticks, int reading_goal);
      int sent;
      sent = 0;
      @(negedge clock);
      while (sent < min_ticks || tracker.readings_done < reading_goal) begin
         if (burst_left == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 40);
         end
         req_tdata <= {5'b0, next_echoes()};
         req_tvalid <= 1'b1;
         burst_left--;
         do @(posedge clock); while (!req_tready);
         sent++;
         @(negedge clock);
      end
      req_tvalid <= 1'b0;
   endtask

   // Wait until every predicted result item has arrived, then a little more
   task automatic settle();
      while (tracker.tick_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] index, logic [23:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      tracker.write_register(index, value);
   endtask

   task automatic program_ranger(logic [10:0] threshold, logic [15:0] timeout,
                                 logic [7:0] trigger, logic [23:0] pause);
      write_csr(CSR_NEAR_THRESHOLD, 24'(threshold));
      write_csr(CSR_ECHO_TIMEOUT, 24'(timeout));
      write_csr(CSR_TRIGGER_TICKS, 24'(trigger));
      write_csr(CSR_PAUSE_TICKS, pause);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int random_ticks0, random_readings0, settings_tried;
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = CSR_NEAR_THRESHOLD;
      csr_wdata = '0;
      tracker = new();
      settings_tried = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: echo widths on either side of a divisor step,
      // then a short way into the long default pause
      script(PLAN_NORMAL, 0, 0);
      script(PLAN_NORMAL, 2, DIV_CM - 1);
      script(PLAN_NORMAL, 1, DIV_CM);
      run_ticks(0, 3);
      run_ticks(10, 0);
      settle();

      // Short timeout, no pause: both kinds of timeout, the timeout hit on
      // the last allowed high tick, the front and right lamps winning
      program_ranger(11'd2, 16'd8, 8'd1, 24'd0);
      script(PLAN_NORMAL, 0, 0);
      script(PLAN_NORMAL, 3, 7);
      script(PLAN_SILENT, 0, 0);
      script(PLAN_STUCK, 2, 0);
      script(PLAN_NORMAL, 0, 8);
      script(PLAN_NORMAL, 0, 0);
      script(PLAN_NOISY, 0, 0);
      script(PLAN_SILENT, 0, 0);
      script(PLAN_NORMAL, 1, 7);
      run_ticks(0, tracker.readings_done + 9);
      settle();

      // Top threshold, one-tick timeout, longest pause
      program_ranger(11'd1129, 16'd1, 8'd4, 24'hFF_FFFF);
      script(PLAN_NORMAL, 0, 0);
      script(PLAN_SILENT, 0, 0);
      script(PLAN_STUCK, 0, 0);
      run_ticks(0, tracker.readings_done + 3);
      run_ticks(10, 0);
      settle();

      // Zero timeout acts as the full wrap, zero trigger as one tick;
      // the new short pause ends the long one at once, nothing lit at threshold zero
      program_ranger(11'd0, 16'd0, 8'd0, 24'd5);
      script(PLAN_NORMAL, 2, 20);
      script(PLAN_NORMAL, 0, DIV_CM);
      script(PLAN_NORMAL, 0, 0);
      run_ticks(0, tracker.readings_done + 3);
      settle();

      // Random settings and echo shapes
      random_ticks0 = tracker.ticks_taken;
      random_readings0 = tracker.readings_done;
      while (tracker.ticks_taken - random_ticks0 < RANDOM_TICKS ||
             tracker.readings_done - random_readings0 < RANDOM_READINGS) begin
         program_ranger(11'($urandom_range(0, 2)),
                        ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom_range(1, 80)),
                        8'($urandom_range(0, 6)),
                        ($urandom_range(0, 3) == 0) ? 24'd0 : 24'($urandom_range(1, 12)));
         run_ticks(16, tracker.readings_done + $urandom_range(1, 3));
         settle();
         settings_tried++;
      end

      $display("ran %0d ticks with %0d random register settings",
               tracker.ticks_taken, settings_tried);
      $display("%0d readings finished, %0d of them by timeout; %0d result items checked",
               tracker.readings_done, tracker.timeouts_seen, tracker.results_checked);
      if (tracker.tick_outputs.size() != 0)
         $display("%0d result items never arrived", tracker.tick_outputs.size());
      if (tracker.errors == 0 && tracker.tick_outputs.size() == 0) begin
         $display("tb_three_sensor_ultrasonic_ranger: PASS");
      end else begin
         $display("%0d mismatches", tracker.errors);
         $display("tb_three_sensor_ultrasonic_ranger: FAIL");
      end
      $finish;
   end

endmodule
